// ----- hdl/vstm_pkg.sv -----
package vstm_pkg;

   localparam logic [1:0] CSR_TOL  = 2'd0;
   localparam logic [1:0] CSR_MAGZ = 2'd1;
   localparam logic [1:0] CSR_CUT  = 2'd2;

   localparam logic [30:0] TOL_RST  = 31'd256;
   localparam logic [31:0] MAGZ_RST = 32'd1356800;
   localparam logic [30:0] CUT_RST  = 31'd20480;

   localparam logic [48:0] X_CLAMP = 49'h1_0000_0000_0000;

   localparam int SQ_W     = 64;
   localparam int SQ_STEPS = 32;

   localparam logic [31:0] SIN_ONE  = 32'd1073741824;
   localparam logic [31:0] SIN_HALF = 32'd759250125;

   // sine of zone*45-90 degrees in q30
   function automatic logic [31:0] zone_sine(input logic [3:0] idx);
      logic [31:0] s;
      unique case (idx)
         4'd0: s = 32'd0 - SIN_ONE;
         4'd1: s = 32'd0 - SIN_HALF;
         4'd2: s = 32'd0;
         4'd3: s = SIN_HALF;
         4'd4: s = SIN_ONE;
         4'd5: s = SIN_HALF;
         4'd6: s = 32'd0;
         4'd7: s = 32'd0 - SIN_HALF;
         4'd8: s = 32'd0 - SIN_ONE;
         default: s = 32'd0;
      endcase
      return s;
   endfunction

   typedef struct packed {
      logic [2:0]  zone;
      logic [31:0] slope;
      logic [31:0] vz;
      logic [31:0] r;
      logic [31:0] dx;
      logic [31:0] dy;
      logic [31:0] dz;
      logic [31:0] dsx;
      logic [32:0] dzv;
      logic [32:0] dzm;
      logic [32:0] dmv;
      logic [63:0] prod_w1;
      logic [63:0] prod_w2;
      logic        slope0;
      logic        qneg;
      logic [64:0] prod_y;
      logic [64:0] prod_xm;
      logic [33:0] ylo;
      logic [33:0] yhi;
      logic [31:0] dmvmag;
      logic [31:0] rmag;
      logic [31:0] smag;
      logic [48:0] xm;
      logic [47:0] qmag;
      logic [48:0] q;
      logic        q0;
      logic [49:0] den;
      logic        den0;
      logic        yneg;
      logic [47:0] dmag;
      logic [63:0] pmag;
      logic [63:0] y;
      logic        pass;
      logic [63:0] uy;
      logic [63:0] r2;
      logic [63:0] bb;
      logic [63:0] ab;
      logic [63:0] y2sq;
      logic [63:0] diff;
      logic [33:0] x;
      logic [63:0] prod3;
      logic        neg3;
      logic [49:0] ext;
      logic [50:0] xv;
      logic [51:0] gap;
   } pl_type;

endpackage

// ----- hdl/vstm_div.sv -----
module vstm_div #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 32,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_vld,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              vld_ff  [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic              vld_src;
      logic [DEN_W-1:0]  rem_src;
      logic [NUM_W-1:0]  nq_src;
      logic [DEN_W-1:0]  den_src;
      logic [SIDE_W-1:0] side_src;
      logic [DEN_W:0]    trial;
      logic              ge;
      logic [DEN_W-1:0]  rem_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_vld;
         assign rem_src  = '0;
         assign nq_src   = in_num;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign nq_src   = nq_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign trial  = {rem_src, nq_src[NUM_W-1]};
      assign ge     = trial >= {1'b0, den_src};
      assign rem_in = ge ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         rem_ff[k]  <= rem_in;
         nq_ff[k]   <= {nq_src[NUM_W-2:0], ge};
         den_ff[k]  <= den_src;
         side_ff[k] <= side_src;
      end
   end

   assign out_vld  = vld_ff[NUM_W-1];
   assign out_quo  = nq_ff[NUM_W-1];
   assign out_side = side_ff[NUM_W-1];

endmodule

// ----- hdl/vstm_sqrt.sv -----
module vstm_sqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic [vstm_pkg::SQ_W-1:0] in_val,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_vld,
   output logic [vstm_pkg::SQ_W/2-1:0] out_root,
   output logic [SIDE_W-1:0]         out_side
);

   localparam int W = vstm_pkg::SQ_W;
   localparam int N = vstm_pkg::SQ_STEPS;

   logic              vld_ff  [N];
   logic [W-1:0]      val_ff  [N];
   logic [W-1:0]      root_ff [N];
   logic [SIDE_W-1:0] side_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
      logic              vld_src;
      logic [W-1:0]      val_src;
      logic [W-1:0]      root_src;
      logic [SIDE_W-1:0] side_src;
      logic [W-1:0]      trial;
      logic              ge;
      logic [W-1:0]      val_in;
      logic [W-1:0]      root_in;

      if (k == 0) begin : g_first
         assign vld_src  = in_vld;
         assign val_src  = in_val;
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign val_src  = val_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign trial   = root_src + BIT;
      assign ge      = val_src >= trial;
      assign val_in  = ge ? val_src - trial : val_src;
      assign root_in = ge ? (root_src >> 1) + BIT : root_src >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
         val_ff[k]  <= val_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_src;
      end
   end

   assign out_vld  = vld_ff[N-1];
   assign out_root = root_ff[N-1][W/2-1:0];
   assign out_side = side_ff[N-1];

endmodule

// ----- hdl/velo_sector_track_match_2d_top.sv -----
// channel   ports                          handshake
// request   start, busy, req_*             taken when start high and busy low
// result    rsp_strobe, rsp_*              one cycle, no backpressure
// csr       csr_valid, csr_ready, csr_*    taken when valid and ready high
//
// fully pipelined, one request per cycle, busy stays low
// 17 stages of glue plus dividers of 48, 64 and 64 stages
// and a 32 stage square root, one quotient or root bit per stage
// reset clears valid bits and csr registers to their defaults
module velo_sector_track_match_2d_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_phi_zone,
   input  logic [31:0] req_velo_r_slope,
   input  logic [31:0] req_velo_z,
   input  logic [31:0] req_velo_radius,
   input  logic [31:0] req_down_x,
   input  logic [31:0] req_down_y,
   input  logic [31:0] req_down_z,
   input  logic [31:0] req_down_x_slope,
   output logic        rsp_strobe,
   output logic        rsp_matched,
   output logic        rsp_y_in_window,
   output logic        rsp_degenerate,
   output logic [31:0] rsp_x_gap,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int PL_W = $bits(vstm_pkg::pl_type);

   logic [30:0] tol_ff;
   logic [31:0] mz_ff;
   logic [30:0] cut_ff;

   vstm_pkg::pl_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff;
   vstm_pkg::pl_type s9_ff, s10_ff, s11_ff, s12_ff, s13_ff, s14_ff, s15_ff, s16_ff;
   vstm_pkg::pl_type s1_in, s2_in, s3_in, s4_in, s5_in, s6_in, s7_in, s8_in;
   vstm_pkg::pl_type s9_in, s10_in, s11_in, s12_in, s13_in, s14_in, s15_in, s16_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff;
   logic v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff, v15_ff, v16_ff;

   logic              d1_vld, d2_vld, d3_vld, sq_vld;
   logic [47:0]       d1_quo;
   logic [63:0]       d2_quo, d3_quo;
   logic [31:0]       sq_root;
   logic [PL_W-1:0]   d1_side, d2_side, d3_side, sq_side;

   logic              accept;
   logic              rsp_strobe_ff, matched_ff, win_ff, deg_ff;
   logic              matched_in, win_in, deg_in;
   logic [31:0]       gap_ff, gap_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= vstm_pkg::TOL_RST;
         mz_ff  <= vstm_pkg::MAGZ_RST;
         cut_ff <= vstm_pkg::CUT_RST;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == vstm_pkg::CSR_TOL) begin
            tol_ff <= csr_data[30:0];
         end
         if (csr_index == vstm_pkg::CSR_MAGZ) begin
            mz_ff <= csr_data;
         end
         if (csr_index == vstm_pkg::CSR_CUT) begin
            cut_ff <= csr_data[30:0];
         end
      end
   end

   // request capture
   always_comb begin
      s1_in       = '0;
      s1_in.zone  = req_phi_zone;
      s1_in.slope = req_velo_r_slope;
      s1_in.vz    = req_velo_z;
      s1_in.r     = req_velo_radius;
      s1_in.dx    = req_down_x;
      s1_in.dy    = req_down_y;
      s1_in.dz    = req_down_z;
      s1_in.dsx   = req_down_x_slope;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      s1_ff <= s1_in;
   end

   // differences and window products
   logic signed [63:0] pw1, pw2;
   assign pw1 = $signed(s1_ff.r) * $signed(vstm_pkg::zone_sine({1'b0, s1_ff.zone}));
   assign pw2 = $signed(s1_ff.r)
              * $signed(vstm_pkg::zone_sine(4'({1'b0, s1_ff.zone}) + 4'd1));

   always_comb begin
      s2_in         = s1_ff;
      s2_in.dzv     = {s1_ff.dz[31], s1_ff.dz} - {s1_ff.vz[31], s1_ff.vz};
      s2_in.dzm     = {s1_ff.dz[31], s1_ff.dz} - {mz_ff[31], mz_ff};
      s2_in.dmv     = {mz_ff[31], mz_ff} - {s1_ff.vz[31], s1_ff.vz};
      s2_in.prod_w1 = pw1;
      s2_in.prod_w2 = pw2;
      s2_in.slope0  = s1_ff.slope == 32'd0;
      s2_in.qneg    = s1_ff.r[31] ^ s1_ff.slope[31];
   end

   // products, window edges, magnitudes
   logic signed [64:0] py, pxm;
   logic [63:0]        w1t, w2t;
   assign py  = $signed(s2_ff.dy) * $signed(s2_ff.dzv);
   assign pxm = $signed(s2_ff.dsx) * $signed(s2_ff.dzm);
   assign w1t = s2_ff.prod_w1 + {34'd0, {30{s2_ff.prod_w1[63]}}};
   assign w2t = s2_ff.prod_w2 + {34'd0, {30{s2_ff.prod_w2[63]}}};

   always_comb begin
      logic [32:0] ndmv;
      ndmv          = 33'd0 - s2_ff.dmv;
      s3_in         = s2_ff;
      s3_in.prod_y  = py;
      s3_in.prod_xm = pxm;
      s3_in.ylo     = w1t[63:30];
      s3_in.yhi     = w2t[63:30];
      s3_in.dmvmag  = s2_ff.dmv[32] ? ndmv[31:0] : s2_ff.dmv[31:0];
      s3_in.rmag    = s2_ff.r[31] ? 32'd0 - s2_ff.r : s2_ff.r;
      s3_in.smag    = s2_ff.slope[31] ? 32'd0 - s2_ff.slope : s2_ff.slope;
   end

   // sort window, add margin, downstream x at magnet
   logic [64:0] xmt;
   assign xmt = s3_ff.prod_xm + {49'd0, {16{s3_ff.prod_xm[64]}}};

   always_comb begin
      logic [33:0] lo, hi;
      if ($signed(s3_ff.ylo) > $signed(s3_ff.yhi)) begin
         lo = s3_ff.yhi;
         hi = s3_ff.ylo;
      end else begin
         lo = s3_ff.ylo;
         hi = s3_ff.yhi;
      end
      s4_in     = s3_ff;
      s4_in.ylo = lo - {3'd0, tol_ff};
      s4_in.yhi = hi + {3'd0, tol_ff};
      s4_in.xm  = {{17{s3_ff.dx[31]}}, s3_ff.dx} - xmt[64:16];
   end

   vstm_div #(.NUM_W(48), .DEN_W(32), .SIDE_W(PL_W)) u_div_q (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v4_ff),
      .in_num   ({s4_ff.rmag, 16'd0}),
      .in_den   (s4_ff.smag),
      .in_side  (s4_ff),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   always_comb begin
      s5_in      = vstm_pkg::pl_type'(d1_side);
      s5_in.qmag = d1_quo;
      s5_in.q    = s5_in.qneg ? 49'd0 - {1'b0, d1_quo} : {1'b0, d1_quo};
   end

   always_comb begin
      s6_in     = s5_ff;
      s6_in.den = {{17{s5_ff.dzv[32]}}, s5_ff.dzv} + {s5_ff.q[48], s5_ff.q};
      s6_in.q0  = s5_ff.q == 49'd0;
   end

   always_comb begin
      logic [49:0] nden;
      logic [64:0] npy;
      nden       = 50'd0 - s6_ff.den;
      npy        = 65'd0 - s6_ff.prod_y;
      s7_in      = s6_ff;
      s7_in.dmag = s6_ff.den[49] ? nden[47:0] : s6_ff.den[47:0];
      s7_in.den0 = s6_ff.den == 50'd0;
      s7_in.yneg = s6_ff.prod_y[64] ^ s6_ff.den[49];
      s7_in.pmag = s6_ff.prod_y[64] ? npy[63:0] : s6_ff.prod_y[63:0];
   end

   vstm_div #(.NUM_W(64), .DEN_W(48), .SIDE_W(PL_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v7_ff),
      .in_num   (s7_ff.pmag),
      .in_den   (s7_ff.dmag),
      .in_side  (s7_ff),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   always_comb begin
      logic [63:0] t;
      s8_in   = vstm_pkg::pl_type'(d2_side);
      t       = s8_in.yneg ? 64'd0 - d2_quo : d2_quo;
      s8_in.y = {{32{s8_in.dy[31]}}, s8_in.dy} - t;
   end

   always_comb begin
      s9_in      = s8_ff;
      s9_in.pass = ($signed(s8_ff.y) > $signed(s8_ff.ylo))
                && ($signed(s8_ff.y) < $signed(s8_ff.yhi));
      s9_in.uy   = s8_ff.y[63] ? 64'd0 - s8_ff.y : s8_ff.y;
   end

   always_comb begin
      s10_in    = s9_ff;
      s10_in.r2 = s9_ff.rmag * s9_ff.rmag;
      s10_in.bb = s9_ff.uy[31:0] * s9_ff.uy[31:0];
      s10_in.ab = s9_ff.uy[63:32] * s9_ff.uy[31:0];
   end

   // low word of the square of y
   always_comb begin
      s11_in      = s10_ff;
      s11_in.y2sq = s10_ff.bb + {s10_ff.ab[30:0], 33'd0};
   end

   always_comb begin
      s12_in      = s11_ff;
      s12_in.diff = (s11_ff.r2 >= s11_ff.y2sq) ? s11_ff.r2 - s11_ff.y2sq
                                                : s11_ff.y2sq - s11_ff.r2;
   end

   vstm_sqrt #(.SIDE_W(PL_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v12_ff),
      .in_val   (s12_ff.diff),
      .in_side  (s12_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   always_comb begin
      logic xneg;
      s13_in       = vstm_pkg::pl_type'(sq_side);
      xneg         = s13_in.zone[2] & (sq_root != 32'd0);
      s13_in.x     = s13_in.zone[2] ? 34'd0 - {2'd0, sq_root} : {2'd0, sq_root};
      s13_in.prod3 = sq_root * s13_in.dmvmag;
      s13_in.neg3  = xneg ^ s13_in.dmv[32] ^ s13_in.qneg;
   end

   vstm_div #(.NUM_W(64), .DEN_W(48), .SIDE_W(PL_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (v13_ff),
      .in_num   (s13_ff.prod3),
      .in_den   (s13_ff.qmag),
      .in_side  (s13_ff),
      .out_vld  (d3_vld),
      .out_quo  (d3_quo),
      .out_side (d3_side)
   );

   always_comb begin
      logic [48:0] m;
      s14_in     = vstm_pkg::pl_type'(d3_side);
      m          = (d3_quo > {15'd0, vstm_pkg::X_CLAMP}) ? vstm_pkg::X_CLAMP : d3_quo[48:0];
      s14_in.ext = s14_in.neg3 ? 50'd0 - {1'b0, m} : {1'b0, m};
   end

   always_comb begin
      s15_in    = s14_ff;
      s15_in.xv = {{17{s14_ff.x[33]}}, s14_ff.x} + {s14_ff.ext[49], s14_ff.ext};
   end

   always_comb begin
      s16_in     = s15_ff;
      s16_in.gap = {s15_ff.xv[50], s15_ff.xv} - {{3{s15_ff.xm[48]}}, s15_ff.xm};
   end

   // cut, saturation and special cases
   always_comb begin
      logic [51:0] cut, ncut;
      logic        in_cut;
      logic [31:0] sat;
      cut    = {21'd0, cut_ff};
      ncut   = 52'd0 - cut;
      in_cut = ($signed(s16_ff.gap) < $signed(cut)) && ($signed(s16_ff.gap) > $signed(ncut));
      if ($signed(s16_ff.gap) > $signed(52'h0_0000_7FFF_FFFF)) begin
         sat = 32'h7FFF_FFFF;
      end else if ($signed(s16_ff.gap) < $signed(52'hF_FFFF_8000_0000)) begin
         sat = 32'h8000_0000;
      end else begin
         sat = s16_ff.gap[31:0];
      end
      matched_in = 1'b0;
      win_in     = 1'b0;
      deg_in     = 1'b0;
      gap_in     = 32'd0;
      priority if (s16_ff.slope0 || s16_ff.den0) begin
         deg_in = 1'b1;
      end else if (!s16_ff.pass) begin
         deg_in = 1'b0;
      end else if (s16_ff.q0) begin
         deg_in = 1'b1;
         win_in = 1'b1;
      end else begin
         win_in     = 1'b1;
         matched_in = in_cut;
         gap_in     = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
         v6_ff         <= 1'b0;
         v7_ff         <= 1'b0;
         v8_ff         <= 1'b0;
         v9_ff         <= 1'b0;
         v10_ff        <= 1'b0;
         v11_ff        <= 1'b0;
         v12_ff        <= 1'b0;
         v13_ff        <= 1'b0;
         v14_ff        <= 1'b0;
         v15_ff        <= 1'b0;
         v16_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         v4_ff         <= v3_ff;
         v5_ff         <= d1_vld;
         v6_ff         <= v5_ff;
         v7_ff         <= v6_ff;
         v8_ff         <= d2_vld;
         v9_ff         <= v8_ff;
         v10_ff        <= v9_ff;
         v11_ff        <= v10_ff;
         v12_ff        <= v11_ff;
         v13_ff        <= sq_vld;
         v14_ff        <= d3_vld;
         v15_ff        <= v14_ff;
         v16_ff        <= v15_ff;
         rsp_strobe_ff <= v16_ff;
      end
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      s4_ff      <= s4_in;
      s5_ff      <= s5_in;
      s6_ff      <= s6_in;
      s7_ff      <= s7_in;
      s8_ff      <= s8_in;
      s9_ff      <= s9_in;
      s10_ff     <= s10_in;
      s11_ff     <= s11_in;
      s12_ff     <= s12_in;
      s13_ff     <= s13_in;
      s14_ff     <= s14_in;
      s15_ff     <= s15_in;
      s16_ff     <= s16_in;
      matched_ff <= matched_in;
      win_ff     <= win_in;
      deg_ff     <= deg_in;
      gap_ff     <= gap_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_matched     = matched_ff;
   assign rsp_y_in_window = win_ff;
   assign rsp_degenerate  = deg_ff;
   assign rsp_x_gap       = gap_ff;

endmodule
